/* rtl/mcfc_pkg.sv */
// Shared constants, types and arithmetic helpers for the MIMO complex FIR channel.
// No dependencies.
`default_nettype none
package mcfc_pkg;
	localparam int MAX_TAPS = 16;
	localparam int MAX_TX = 2;
	localparam int MAX_RX = 2;
	localparam int NUM_PATHS = MAX_TX * MAX_RX;
	localparam int TAP_W = $clog2(MAX_TAPS);
	localparam int PATH_W = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	// Sum of MAX_TX*MAX_TAPS products of 33 bits each.
	localparam int ACC_W = 34 + $clog2(MAX_TX * MAX_TAPS + 1);

	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_TAPS = 2'd1;
	localparam logic [1:0] REG_TX = 2'd2;
	localparam logic [1:0] REG_RX = 2'd3;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
	} cplx_t;

	// Per-cycle control broadcast along the cell chain.
	typedef struct packed {
		logic shift;
		logic clear;
		logic [MAX_TX-1:0] tx_en;
	} cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/mcfc_tap_cell.sv */
// One delay position of the channel: history per transmit antenna and the taps
// of all paths; forms the complex products for both receive antennas. Uses mcfc_pkg.
`default_nettype none
module mcfc_tap_cell
	import mcfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic                  tap_en,
	input  wire logic                  load_we,
	input  wire logic [PATH_W-1:0]     load_path,
	input  wire cplx_t                 load_val,
	input  wire logic [1:0]            nrx,
	input  wire cplx_t [MAX_TX-1:0]    hist_in,
	output cplx_t [MAX_TX-1:0]         hist_out,
	output logic signed [34:0]         prod_re [MAX_RX],
	output logic signed [34:0]         prod_im [MAX_RX]
);
	cplx_t [MAX_TX-1:0] hist_q;
	cplx_t tap_q [NUM_PATHS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			for (int p = 0; p < NUM_PATHS; p++) tap_q[p] <= '0;
		end else begin
			if (ctl.clear) hist_q <= '0;
			else if (ctl.shift) hist_q <= hist_in;
			if (load_we) tap_q[load_path] <= load_val;
		end
	end
	assign hist_out = hist_q;

	always_comb begin
		logic signed [34:0] sr, si;
		logic [3:0] path;
		cplx_t t;
		for (int r = 0; r < MAX_RX; r++) begin
			sr = '0;
			si = '0;
			for (int x = 0; x < MAX_TX; x++) begin
				path = 4'(r) + 4'(x) * {2'b00, nrx};
				t = (path < 4'(NUM_PATHS)) ? tap_q[path[PATH_W-1:0]] : '0;
				if (tap_en && ctl.tx_en[x] && path < 4'(NUM_PATHS)) begin
					sr = sr + 35'(hist_q[x].re * t.re) - 35'(hist_q[x].im * t.im);
					si = si + 35'(hist_q[x].im * t.re) + 35'(hist_q[x].re * t.im);
				end
			end
			prod_re[r] = sr;
			prod_im[r] = si;
		end
	end
endmodule
`default_nettype wire

/* rtl/mcfc_scale.sv */
// Gain multiply, round half up by 2^30 and saturation of one component.
// Uses mcfc_pkg.
`default_nettype none
module mcfc_scale
	import mcfc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic signed [ACC_W-1:0]  acc,
	input  wire logic [15:0]              gain,
	output logic signed [15:0]            y,
	output logic                          clip
);
	logic signed [ACC_W+17:0] prod_s1;
	logic signed [ACC_W-12:0] q;

	always_ff @(posedge clk) prod_s1 <= acc * $signed({2'b00, gain});

	always_comb begin
		q = (ACC_W-11)'((prod_s1 + (ACC_W+18)'(64'sd1 <<< 29)) >>> 30);
		clip = 1'b1;
		if (q > 32767) y = 16'sd32767;
		else if (q < -32768) y = -16'sd32768;
		else begin
			y = q[15:0];
			clip = 1'b0;
		end
	end
endmodule
`default_nettype wire

/* rtl/mimo_complex_fir_channel.sv */
// MIMO complex FIR channel emulator: top level with the cell chain, adder stage,
// scaling and output register. Uses mcfc_pkg, mcfc_tap_cell, mcfc_scale.
//
// Usage: s_axis carries load and sample transactions (see tdata map). A load
// writes one complex tap and produces nothing. A sample shifts the history
// chain of MAX_TAPS cells and produces one m_axis transaction with the
// filtered output of the enabled receive antennas (zero for the others); tlast
// copies frame_end and the history is zeroed after a frame end. Every cell
// multiplies its history by its taps in parallel; products, tree sums and gain
// are registered in three stages ahead of the output register. One sample is
// in flight at a time: the next item is accepted in the cycle after its result
// is taken, while a load produces no result and does not hold up the next item.
// The output register holds its result while m_axis_tready is low, which holds
// up the next item; s_axis_tready is low until that result is taken. Reset
// clears history, taps and registers to their defaults (gain 32768, 16 taps,
// one tx, one rx). The user writes configuration through cfg_we/cfg_addr/cfg_data
// only while idle; the block itself does not enforce this.
`default_nettype none
module mimo_complex_fir_channel
	import mcfc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// action, tap_slot, path_slot, coef_real, coef_imag, tx0_real, tx0_imag,
	// tx1_real, tx1_imag, zero pad to 104 bits
	input  wire logic [103:0] s_axis_tdata,
	input  wire logic         s_axis_tlast,  // frame_end
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// rx0_real, rx0_imag, rx1_real, rx1_imag
	output logic [63:0]       m_axis_tdata,
	output logic              m_axis_tlast,  // frame_last
	output logic              m_axis_tuser   // clipped
);
	function automatic logic [MAX_RX-1:0] nrx_mask(input logic [1:0] n);
		logic [MAX_RX-1:0] m;
		for (int r = 0; r < MAX_RX; r++) m[r] = (2'(r) < n);
		return m;
	endfunction

	logic [15:0] gain_q;
	logic [4:0] taps_q;
	logic [1:0] ntx_q, nrx_q;
	logic [1:0] nrx, ntx;
	logic [CNT_W-1:0] ntaps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd32768;
			taps_q <= 5'd16;
			ntx_q <= 2'd1;
			nrx_q <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GAIN: gain_q <= cfg_data;
				REG_TAPS: taps_q <= cfg_data[4:0];
				REG_TX: ntx_q <= cfg_data[1:0];
				REG_RX: nrx_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign ntaps = (taps_q == 0) ? CNT_W'(1)
		: (taps_q > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(taps_q);
	assign ntx = (ntx_q == 0) ? 2'd1 : (ntx_q > MAX_TX) ? 2'(MAX_TX) : ntx_q;
	assign nrx = (nrx_q == 0) ? 2'd1 : (nrx_q > MAX_RX) ? 2'(MAX_RX) : nrx_q;

	// input fields
	logic in_act, in_fire, busy_q;
	logic [3:0] in_tap;
	logic [1:0] in_path;
	cplx_t coef;
	cplx_t [MAX_TX-1:0] tx_in;
	assign in_act = s_axis_tdata[0];
	assign in_tap = s_axis_tdata[4:1];
	assign in_path = s_axis_tdata[6:5];
	assign coef = {s_axis_tdata[22:7], s_axis_tdata[38:23]};
	always_comb begin
		tx_in = '0;
		tx_in[0] = {s_axis_tdata[54:39], s_axis_tdata[70:55]};
		if (MAX_TX > 1) tx_in[MAX_TX > 1 ? 1 : 0] = {s_axis_tdata[86:71], s_axis_tdata[102:87]};
	end

	assign s_axis_tready = !busy_q && !m_axis_tvalid;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// sequencer: shift at s0, products s1, tree sum s2, scale s3, output
	logic sh_s1, prd_s2, sum_s3, last_s1, last_s2, pend_clr_q;
	logic [MAX_TX-1:0] tx_en;
	cell_ctl_t ctl;
	always_comb begin
		for (int x = 0; x < MAX_TX; x++) tx_en[x] = (2'(x) < ntx);
		ctl.shift = in_fire && in_act == ACT_SAMPLE;
		ctl.clear = pend_clr_q;
		ctl.tx_en = tx_en;
	end

	logic load_ok;
	assign load_ok = in_fire && in_act == ACT_LOAD && 32'(in_tap) < MAX_TAPS
		&& 32'(in_path) < NUM_PATHS;

	cplx_t [MAX_TX-1:0] chain [MAX_TAPS+1];
	logic signed [34:0] pr [MAX_TAPS][MAX_RX];
	logic signed [34:0] pi [MAX_TAPS][MAX_RX];
	assign chain[0] = tx_in;

	for (genvar l = 0; l < MAX_TAPS; l++) begin : g_cell
		mcfc_tap_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.tap_en(CNT_W'(l) < ntaps),
			.load_we(load_ok && in_tap[TAP_W-1:0] == TAP_W'(l)),
			.load_path(in_path[PATH_W-1:0]), .load_val(coef), .nrx(nrx),
			.hist_in(chain[l]), .hist_out(chain[l+1]),
			.prod_re(pr[l]), .prod_im(pi[l])
		);
	end

	logic signed [34:0] pr_s2 [MAX_TAPS][MAX_RX];
	logic signed [34:0] pi_s2 [MAX_TAPS][MAX_RX];
	always_ff @(posedge clk) begin
		pr_s2 <= pr;
		pi_s2 <= pi;
	end

	// balanced adder tree over the registered cell products
	logic signed [ACC_W-1:0] tree_re [MAX_TAPS];
	logic signed [ACC_W-1:0] tree_im [MAX_TAPS];
	logic signed [ACC_W-1:0] sum_re [MAX_RX];
	logic signed [ACC_W-1:0] sum_im [MAX_RX];
	always_comb begin
		for (int r = 0; r < MAX_RX; r++) begin
			for (int l = 0; l < MAX_TAPS; l++) begin
				tree_re[l] = ACC_W'(pr_s2[l][r]);
				tree_im[l] = ACC_W'(pi_s2[l][r]);
			end
			for (int w = MAX_TAPS; w > 1; w = (w + 1) >> 1) begin
				for (int i = 0; i < (w >> 1); i++) begin
					tree_re[i] = tree_re[2*i] + tree_re[2*i+1];
					tree_im[i] = tree_im[2*i] + tree_im[2*i+1];
				end
				if (w[0]) begin
					tree_re[w >> 1] = tree_re[w-1];
					tree_im[w >> 1] = tree_im[w-1];
				end
			end
			sum_re[r] = tree_re[0];
			sum_im[r] = tree_im[0];
		end
	end

	logic signed [ACC_W-1:0] acc_re_s3 [MAX_RX];
	logic signed [ACC_W-1:0] acc_im_s3 [MAX_RX];
	always_ff @(posedge clk) begin
		for (int r = 0; r < MAX_RX; r++) begin
			acc_re_s3[r] <= (2'(r) < nrx) ? sum_re[r] : '0;
			acc_im_s3[r] <= (2'(r) < nrx) ? sum_im[r] : '0;
		end
	end

	logic signed [15:0] y_re [MAX_RX];
	logic signed [15:0] y_im [MAX_RX];
	logic [MAX_RX-1:0] c_re, c_im;
	for (genvar r = 0; r < MAX_RX; r++) begin : g_scale
		mcfc_scale u_sre (.clk(clk), .acc(acc_re_s3[r]), .gain(gain_q),
			.y(y_re[r]), .clip(c_re[r]));
		mcfc_scale u_sim (.clk(clk), .acc(acc_im_s3[r]), .gain(gain_q),
			.y(y_im[r]), .clip(c_im[r]));
	end

	logic sc_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sh_s1 <= 1'b0;
			prd_s2 <= 1'b0;
			sum_s3 <= 1'b0;
			sc_s4 <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			m_axis_tlast <= 1'b0;
			pend_clr_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tuser <= 1'b0;
		end else begin
			sh_s1 <= ctl.shift;
			prd_s2 <= sh_s1;
			sum_s3 <= prd_s2;
			sc_s4 <= sum_s3;
			if (ctl.shift) begin
				busy_q <= 1'b1;
				last_s1 <= s_axis_tlast;
			end
			last_s2 <= last_s1;
			// clear history once products of the frame-end sample are registered
			pend_clr_q <= sh_s1 && last_s1;
			if (sc_s4) begin
				busy_q <= 1'b0;
				m_axis_tvalid <= 1'b1;
				m_axis_tlast <= last_s2;
				m_axis_tdata <= (MAX_RX > 1)
					? {y_im[MAX_RX > 1 ? 1 : 0], y_re[MAX_RX > 1 ? 1 : 0], y_im[0], y_re[0]}
					: {32'd0, y_im[0], y_re[0]};
				m_axis_tuser <= |({c_re, c_im} & {nrx_mask(nrx), nrx_mask(nrx)});
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

/* tb/sv/mimo_complex_fir_channel_test.sv */
// Self-checking testbench for mimo_complex_fir_channel: tap loads, MIMO sample
// filtering, gain, saturation and frame clears, checked against an in-bench predictor.
// Depends on mcfc_pkg and the RTL top level only.
`default_nettype none
module mimo_complex_fir_channel_test
	import mcfc_pkg::*;
;

	typedef struct packed {
		logic         frame_end;
		logic [103:0] data;
	} s_item_t;

	typedef struct packed {
		logic [63:0] data;
		logic        frame_last;
		logic        clipped;
	} rx_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_addr = '0;
	logic [15:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata = '0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         m_axis_tuser;

	mimo_complex_fir_channel i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic signed [15:0] hist_re [MAX_TX][MAX_TAPS];
	logic signed [15:0] hist_im [MAX_TX][MAX_TAPS];
	logic signed [15:0] coef_re [NUM_PATHS][MAX_TAPS];
	logic signed [15:0] coef_im [NUM_PATHS][MAX_TAPS];
	logic [15:0] gain_q15;
	logic [4:0]  tap_count;
	logic [1:0]  tx_count, rx_count;

	s_item_t    pending_items[$];
	rx_result_t expected_rx[$];
	int  errors = 0;
	int  send_idle_pct = 0, recv_stall_pct = 0;
	int  cycle_count = 0;
	bit  in_taken = 1'b0;

	function automatic logic signed [15:0] round_sat(input longint x, inout logic clip);
		longint q;
		q = (x + (64'sd1 <<< 29)) >>> 30;
		if (q > 32767) begin
			clip = 1'b1;
			return 16'sh7fff;
		end
		if (q < -32768) begin
			clip = 1'b1;
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	function automatic int clamp_cnt(input int v, input int hi);
		return (v < 1) ? 1 : (v > hi) ? hi : v;
	endfunction

	// Applies one accepted input to the predictor; queues a result for samples.
	task automatic channel_predict(input s_item_t it);
		int ntaps, ntx, nrx, path;
		longint acc_re, acc_im, a, b, c, d;
		logic clip;
		logic [15:0] outv [4];
		if (it.data[0] == ACT_LOAD) begin
			coef_re[it.data[6:5]][it.data[4:1]] = it.data[22:7];
			coef_im[it.data[6:5]][it.data[4:1]] = it.data[38:23];
			return;
		end
		for (int t = 0; t < MAX_TX; t++) begin
			for (int l = MAX_TAPS - 1; l > 0; l--) begin
				hist_re[t][l] = hist_re[t][l-1];
				hist_im[t][l] = hist_im[t][l-1];
			end
			hist_re[t][0] = it.data[39 + 32*t +: 16];
			hist_im[t][0] = it.data[55 + 32*t +: 16];
		end
		ntaps = clamp_cnt(tap_count, MAX_TAPS);
		ntx = clamp_cnt(tx_count, MAX_TX);
		nrx = clamp_cnt(rx_count, MAX_RX);
		clip = 1'b0;
		for (int k = 0; k < 4; k++) outv[k] = '0;
		for (int r = 0; r < nrx; r++) begin
			acc_re = 0;
			acc_im = 0;
			for (int t = 0; t < ntx; t++) begin
				path = r + t * nrx;
				if (path >= NUM_PATHS) continue;
				for (int l = 0; l < ntaps; l++) begin
					a = hist_re[t][l];
					b = hist_im[t][l];
					c = coef_re[path][l];
					d = coef_im[path][l];
					acc_re += a * c - b * d;
					acc_im += b * c + a * d;
				end
			end
			outv[2*r] = round_sat(acc_re * longint'(gain_q15), clip);
			outv[2*r+1] = round_sat(acc_im * longint'(gain_q15), clip);
		end
		expected_rx.push_back('{data: {outv[3], outv[2], outv[1], outv[0]},
			frame_last: it.frame_end, clipped: clip});
		if (it.frame_end) begin
			foreach (hist_re[t, l]) begin
				hist_re[t][l] = '0;
				hist_im[t][l] = '0;
			end
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
				// hold current transaction
			end else if (pending_items.size() > 0 &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				s_item_t it;
				it = pending_items.pop_front();
				s_axis_tdata <= it.data;
				s_axis_tlast <= it.frame_end;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				channel_predict('{frame_end: s_axis_tlast, data: s_axis_tdata});
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_rx.size() == 0) begin
					$display("%0t: unexpected result data=%h last=%b clip=%b", $time,
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
					errors++;
				end else begin
					rx_result_t exp_r;
					exp_r = expected_rx.pop_front();
					if (exp_r.data !== m_axis_tdata) begin
						$display("%0t: data expected %h actual %h", $time,
							exp_r.data, m_axis_tdata);
						errors++;
					end
					if (exp_r.frame_last !== m_axis_tlast) begin
						$display("%0t: frame_last expected %b actual %b", $time,
							exp_r.frame_last, m_axis_tlast);
						errors++;
					end
					if (exp_r.clipped !== m_axis_tuser) begin
						$display("%0t: clipped expected %b actual %b", $time,
							exp_r.clipped, m_axis_tuser);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > 1500000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [15:0] rand16();
		case ($urandom_range(7, 0))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic add_load(input int tap, input int path, input logic [15:0] cr,
			input logic [15:0] ci);
		s_item_t it;
		it = '0;
		it.data[0] = ACT_LOAD;
		it.data[4:1] = 4'(tap);
		it.data[6:5] = 2'(path);
		it.data[22:7] = cr;
		it.data[38:23] = ci;
		it.data[102:39] = {$urandom(), $urandom()};
		it.frame_end = 1'($urandom_range(1, 0));
		pending_items.push_back(it);
	endtask

	task automatic add_sample(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d, input logic fe);
		s_item_t it;
		it = '0;
		it.data[0] = ACT_SAMPLE;
		it.data[38:1] = 38'({$urandom(), $urandom()});
		it.data[102:39] = {d, c, b, a};
		it.frame_end = fe;
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || s_axis_tvalid || expected_rx.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GAIN: gain_q15 = val;
			REG_TAPS: tap_count = val[4:0];
			REG_TX: tx_count = val[1:0];
			default: rx_count = val[1:0];
		endcase
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99, 0) < 25)
				add_load($urandom_range(15, 0), $urandom_range(3, 0), rand16(), rand16());
			else
				add_sample(rand16(), rand16(), rand16(), rand16(),
					$urandom_range(19, 0) == 0);
		end
	endtask

	initial begin
		int idle_mode [4];
		int stall_mode [4];
		idle_mode = '{0, 87, 0, 20};
		stall_mode = '{0, 0, 87, 20};
		foreach (hist_re[t, l]) begin
			hist_re[t][l] = '0;
			hist_im[t][l] = '0;
		end
		foreach (coef_re[p, l]) begin
			coef_re[p][l] = '0;
			coef_im[p][l] = '0;
		end
		gain_q15 = 16'd32768;
		tap_count = 5'd16;
		tx_count = 2'd1;
		rx_count = 2'd1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: full scale taps and samples, saturation, frame end, all paths
		write_reg(REG_GAIN, 16'hffff);
		write_reg(REG_TAPS, 16'd16);
		write_reg(REG_TX, 16'd2);
		write_reg(REG_RX, 16'd2);
		for (int p = 0; p < NUM_PATHS; p++) begin
			add_load(0, p, 16'h7fff, 16'h8000);
			add_load(15, p, 16'h8000, 16'h7fff);
		end
		add_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		add_sample(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b0);
		add_sample(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0);
		add_sample(16'hffff, 16'h0001, 16'h5555, 16'haaaa, 1'b1);
		add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
		add_sample(16'h1234, 16'hfedc, 16'h0001, 16'hffff, 1'b1);
		wait_idle();
		// zero tap, tx and rx register values act as one; the gain is zero too
		write_reg(REG_GAIN, 16'h0000);
		write_reg(REG_TAPS, 16'd0);
		write_reg(REG_TX, 16'd0);
		write_reg(REG_RX, 16'd0);
		add_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
		wait_idle();
		write_reg(REG_GAIN, 16'h8000);
		write_reg(REG_TAPS, 16'd31);
		write_reg(REG_TX, 16'd3);
		write_reg(REG_RX, 16'd3);
		add_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1);
		add_sample(16'h4000, 16'hc000, 16'h2000, 16'he000, 1'b0);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = idle_mode[ph % 4];
			recv_stall_pct = stall_mode[ph % 4];
			write_reg(REG_GAIN, (ph % 3 == 0) ? 16'hffff : 16'($urandom()));
			write_reg(REG_TAPS, (ph == 2) ? 16'd1 : 16'($urandom_range(16, 1)));
			write_reg(REG_TX, 16'($urandom_range(2, 1)));
			write_reg(REG_RX, 16'($urandom_range(2, 1)));
			random_phase(145);
			wait_idle();
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
rtl/mcfc_pkg.sv
rtl/mcfc_tap_cell.sv
rtl/mcfc_scale.sv
rtl/mimo_complex_fir_channel.sv
tb/sv/mimo_complex_fir_channel_test.sv
